@@ hdl/tlas_pkg.sv @@
// Shared types and constants for the text line assembler with scrollback.
// Used by the slot unit, the history store, the top module and the testbench; no dependencies of its own.
package tlas_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE     = 8'd10;
    localparam logic [7:0] CH_TAB         = 8'd9;
    localparam logic [7:0] CH_SPACE       = 8'd32;
    localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [7:0] CH_PAST_PRINT  = 8'd127;
    localparam logic [2:0] TAB_STOP       = 3'd4;

    // controls of the shared slot / row-base unit
    typedef struct packed {
        logic sum_en;   // register wrapped slot = a + b mod depth
        logic mul_en;   // register row base = slot * row length
    } slot_ctl_t;

    // controls of the history store
    typedef struct packed {
        logic char_we;
        logic char_re;
        logic len_we;
        logic len_re;
    } hist_ctl_t;

endpackage

@@ hdl/tlas_slot_unit.sv @@
// Shared address unit: ring slot add with wrap, then row base multiply.
// Depends on tlas_pkg for the control struct.
module tlas_slot_unit
    import tlas_pkg::*;
#(
    parameter int HISTORY_LINES = 256,
    parameter int LINE_COLS     = 90,
    parameter int SLOT_W        = 8,
    parameter int ADDR_W        = 15
) (
    input  logic              aclk,
    input  slot_ctl_t         ctl,
    input  logic [SLOT_W-1:0] opnd_a,
    input  logic [SLOT_W-1:0] opnd_b,
    output logic [SLOT_W-1:0] slot,
    output logic [ADDR_W-1:0] base
);

    logic [SLOT_W:0]   sum;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] base_reg;

    assign sum = {1'b0, opnd_a} + {1'b0, opnd_b};

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            if (sum >= (SLOT_W+1)'(HISTORY_LINES)) begin
                slot_reg <= SLOT_W'(sum - (SLOT_W+1)'(HISTORY_LINES));
            end else begin
                slot_reg <= sum[SLOT_W-1:0];
            end
        end
        if (ctl.mul_en) begin
            base_reg <= ADDR_W'(slot_reg) * ADDR_W'(LINE_COLS);
        end
    end

    assign slot = slot_reg;
    assign base = base_reg;

endmodule

@@ hdl/tlas_line_buf.sv @@
// Partial line store: one write port, one registered read port.
// Depends on nothing but its parameters.
module tlas_line_buf #(
    parameter int LINE_COLS = 90,
    parameter int COL_W     = 7
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] line_mem [LINE_COLS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tlas_history.sv @@
// History store: character rows and line lengths, each one write and one read port.
// Depends on tlas_pkg for the control struct.
module tlas_history
    import tlas_pkg::*;
#(
    parameter int HISTORY_LINES = 256,
    parameter int LINE_COLS     = 90,
    parameter int SLOT_W        = 8,
    parameter int COL_W         = 7,
    parameter int LEN_W         = 7,
    parameter int ADDR_W        = 15
) (
    input  logic              aclk,
    input  hist_ctl_t         ctl,
    input  logic [SLOT_W-1:0] slot,
    input  logic [ADDR_W-1:0] base,
    input  logic [COL_W-1:0]  wr_off,
    input  logic [7:0]        wr_char,
    input  logic [6:0]        rd_off,
    input  logic [LEN_W-1:0]  wr_len,
    output logic [7:0]        rd_char,
    output logic [LEN_W-1:0]  rd_len
);

    logic [7:0]       char_mem [HISTORY_LINES*LINE_COLS];
    logic [LEN_W-1:0] len_mem  [HISTORY_LINES];
    logic [7:0]       rd_char_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = base + ADDR_W'(wr_off);
    assign rd_addr = base + ADDR_W'(rd_off);

    always_ff @(posedge aclk) begin
        if (ctl.char_we) begin
            char_mem[wr_addr] <= wr_char;
        end
        if (ctl.char_re) begin
            rd_char_reg <= char_mem[rd_addr];
        end
        if (ctl.len_we) begin
            len_mem[slot] <= wr_len;
        end
        if (ctl.len_re) begin
            rd_len_reg <= len_mem[slot];
        end
    end

    assign rd_char = rd_char_reg;
    assign rd_len  = rd_len_reg;

endmodule

@@ hdl/text_line_assembler_scrollback.sv @@
// Text line assembler with a ring scrollback history. One transaction is taken at a
// time: s_tready is high only while the sequencer is idle, and a finished result may
// wait in the output register while the next transaction is taken. A tab pads with
// spaces to the next tab stop, one padding space per cycle into the line buffer's
// write port. A history read passes through the slot add, the row base multiply and
// the registered memory read. A newline commit runs the copy loop, moving one
// character per cycle from the line buffer into history memory, as does a printable
// byte that fills the line. A result the receiver has not taken adds its wait to the
// next result. No clearing pass runs after reset.
module text_line_assembler_scrollback
    import tlas_pkg::*;
#(
    parameter int LINE_COLS     = 90,
    parameter int HISTORY_LINES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], line_index[15:8], column[22:16], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_char[7:0], line_count[16:8],
                                   // partial_length[23:17], line_committed[24], zero
);

    localparam int LEN_W  = $clog2(LINE_COLS + 1);
    localparam int COL_W  = $clog2(LINE_COLS);
    localparam int SLOT_W = $clog2(HISTORY_LINES);
    localparam int HELD_W = $clog2(HISTORY_LINES + 1);
    localparam int ADDR_W = $clog2(HISTORY_LINES * LINE_COLS);
    localparam int IDX_W  = (HELD_W > 8) ? HELD_W : 8;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_RDREQ = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        idx_reg, idx_next;
    logic [6:0]        col_reg, col_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [7:0]        fill_char_reg, fill_char_next;
    logic [2:0]        fill_cnt_reg, fill_cnt_next;
    logic [LEN_W-1:0]  fill_lim_reg, fill_lim_next;
    logic              commit_reg, commit_next;
    logic              hit_reg, hit_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [COL_W-1:0]  wr_idx_reg, wr_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;

    logic [7:0]        in_byte;
    logic [7:0]        in_idx;
    logic [6:0]        in_col;
    logic              full;
    logic              col_in_row;

    slot_ctl_t         slot_ctl;
    logic [SLOT_W-1:0] opnd_b;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] base;

    hist_ctl_t         hist_ctl;
    logic [7:0]        hist_char;
    logic [LEN_W-1:0]  hist_len;

    logic              lb_wr_en;
    logic              lb_rd_en;
    logic [7:0]        lb_rd_data;
    logic [7:0]        resp_char;

    assign in_byte    = s_tdata[7:0];
    assign in_idx     = s_tdata[15:8];
    assign in_col     = s_tdata[22:16];
    assign full       = (held_reg == HELD_W'(HISTORY_LINES));
    assign col_in_row = (9'(col_reg) < 9'(LINE_COLS));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // b operand: line index for a read, fill position for a commit
    assign opnd_b = (op_reg == OP_READ) ? SLOT_W'(idx_reg) :
                    (full ? '0 : SLOT_W'(held_reg));

    assign resp_char = (op_reg == OP_READ && hit_reg && col_in_row &&
                        9'(col_reg) < 9'(hist_len)) ? hist_char : 8'd0;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        len_next       = len_reg;
        held_next      = held_reg;
        oldest_next    = oldest_reg;
        fill_char_next = fill_char_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_lim_next  = fill_lim_reg;
        commit_next    = commit_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        wr_idx_next    = wr_idx_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        slot_ctl       = '0;
        hist_ctl       = '0;
        lb_wr_en       = 1'b0;
        lb_rd_en       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    idx_next    = in_idx;
                    col_next    = in_col;
                    commit_next = 1'b0;
                    hit_next    = 1'b0;
                    state_next  = S_RESP;
                    unique case (s_tuser)
                        OP_PUT: begin
                            if (in_byte == CH_NEWLINE) begin
                                commit_next = 1'b1;
                                state_next  = S_SLOT;
                            end else if (in_byte == CH_TAB) begin
                                fill_char_next = CH_SPACE;
                                fill_cnt_next  = TAB_STOP - {1'b0, len_reg[1:0]};
                                fill_lim_next  = LEN_W'(LINE_COLS - 1);
                                state_next     = S_FILL;
                            end else if (in_byte >= CH_FIRST_PRINT &&
                                         in_byte < CH_PAST_PRINT) begin
                                fill_char_next = in_byte;
                                fill_cnt_next  = 3'd1;
                                fill_lim_next  = LEN_W'(LINE_COLS);
                                state_next     = S_FILL;
                            end
                        end
                        OP_READ: begin
                            if (IDX_W'(in_idx) < IDX_W'(held_reg)) begin
                                hit_next   = 1'b1;
                                state_next = S_SLOT;
                            end
                        end
                        OP_CLEAR: begin
                            held_next   = '0;
                            oldest_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                // append one character per cycle until the count or the limit runs out
                if (fill_cnt_reg != 3'd0 && len_reg < fill_lim_reg) begin
                    lb_wr_en      = 1'b1;
                    len_next      = len_reg + 1'b1;
                    fill_cnt_next = fill_cnt_reg - 3'd1;
                end else if (len_reg >= LEN_W'(LINE_COLS)) begin
                    commit_next = 1'b1;
                    state_next  = S_SLOT;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SLOT: begin
                slot_ctl.sum_en = 1'b1;
                if (op_reg != OP_READ) begin
                    if (full) begin
                        oldest_next = (oldest_reg == SLOT_W'(HISTORY_LINES - 1)) ? '0 :
                                      oldest_reg + 1'b1;
                    end else begin
                        held_next = held_reg + 1'b1;
                    end
                end
                state_next = S_BASE;
            end
            S_BASE: begin
                slot_ctl.mul_en = 1'b1;
                cnt_next        = '0;
                if (op_reg == OP_READ) begin
                    state_next = S_RDREQ;
                end else begin
                    hist_ctl.len_we = 1'b1;
                    state_next      = S_COPY;
                end
            end
            S_COPY: begin
                // read line buffer at cnt, write history in the following cycle
                if (cnt_reg < len_reg) begin
                    lb_rd_en     = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_idx_next  = cnt_reg[COL_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                hist_ctl.char_we = wr_pend_reg;
                if (cnt_reg >= len_reg && !wr_pend_reg) begin
                    len_next   = '0;
                    state_next = S_RESP;
                end
            end
            S_RDREQ: begin
                hist_ctl.len_re  = 1'b1;
                hist_ctl.char_re = col_in_row;
                state_next       = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, commit_reg, 7'(len_reg), 9'(held_reg), resp_char};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            held_reg    <= '0;
            oldest_reg  <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            held_reg    <= held_next;
            oldest_reg  <= oldest_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        col_reg       <= col_next;
        fill_char_reg <= fill_char_next;
        fill_cnt_reg  <= fill_cnt_next;
        fill_lim_reg  <= fill_lim_next;
        commit_reg    <= commit_next;
        hit_reg       <= hit_next;
        cnt_reg       <= cnt_next;
        wr_idx_reg    <= wr_idx_next;
        m_data_reg    <= m_data_next;
    end

    tlas_slot_unit #(
        .HISTORY_LINES (HISTORY_LINES),
        .LINE_COLS     (LINE_COLS),
        .SLOT_W        (SLOT_W),
        .ADDR_W        (ADDR_W)
    ) u_slot_unit (
        .aclk   (aclk),
        .ctl    (slot_ctl),
        .opnd_a (oldest_reg),
        .opnd_b (opnd_b),
        .slot   (slot),
        .base   (base)
    );

    tlas_line_buf #(
        .LINE_COLS (LINE_COLS),
        .COL_W     (COL_W)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (lb_wr_en),
        .wr_addr (len_reg[COL_W-1:0]),
        .wr_data (fill_char_reg),
        .rd_en   (lb_rd_en),
        .rd_addr (cnt_reg[COL_W-1:0]),
        .rd_data (lb_rd_data)
    );

    tlas_history #(
        .HISTORY_LINES (HISTORY_LINES),
        .LINE_COLS     (LINE_COLS),
        .SLOT_W        (SLOT_W),
        .COL_W         (COL_W),
        .LEN_W         (LEN_W),
        .ADDR_W        (ADDR_W)
    ) u_history (
        .aclk    (aclk),
        .ctl     (hist_ctl),
        .slot    (slot),
        .base    (base),
        .wr_off  (wr_idx_reg),
        .wr_char (lb_rd_data),
        .rd_off  (col_reg),
        .wr_len  (len_reg),
        .rd_char (hist_char),
        .rd_len  (hist_len)
    );

    // the oldest pointer moves only while the history is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (oldest_reg != '0) |-> full)
        else $error("oldest slot moved while history not full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HELD_W'(HISTORY_LINES))
        else $error("line count above history depth");

    // a line never rests full between transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (len_reg < LEN_W'(LINE_COLS)))
        else $error("partial line left at full length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result presented outside response state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        hist_ctl.char_we |-> (state_reg == S_COPY && op_reg != OP_READ))
        else $error("history write outside line copy");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for text_line_assembler_scrollback: streams put/read/clear transactions
// and checks every status result against a shadow line buffer and ring history.
// Depends on tlas_pkg for operation codes and character constants.
module tb_top
    import tlas_pkg::*;
();

    localparam int LINE_COLS    = 90;
    localparam int RING_DEPTH   = 256;
    localparam int N_ITEMS      = 1150;
    localparam int IDLE_PCT     = 33;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [7:0] line_index;
        logic [6:0] column;
    } term_cmd_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic [8:0] line_count;
        logic [6:0] partial_length;
        logic       line_committed;
    } term_status_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // data_byte[7:0], line_index[15:8], column[22:16], zero
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // read_char[7:0], line_count[16:8],
                                  // partial_length[23:17], line_committed[24], zero

    text_line_assembler_scrollback #(
        .LINE_COLS    (LINE_COLS),
        .HISTORY_LINES(RING_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    term_cmd_t    byte_cmd_q[$];
    term_status_t status_due_q[$];
    int           errors       = 0;
    int           items_taken  = 0;
    int           results_seen = 0;
    int           hold_left    = 0;

    // shadow of the line buffer and the ring history
    logic [7:0] line_buf [LINE_COLS];
    int         line_fill = 0;
    logic [7:0] ring_chars [RING_DEPTH][LINE_COLS];
    int         ring_len [RING_DEPTH];
    int         ring_head = 0;
    int         ring_fill = 0;

    task automatic commit_shadow_line();
        int slot;
        if (ring_fill >= RING_DEPTH) begin
            // overwrite the oldest line and advance the head
            slot = ring_head;
            ring_head = (ring_head + 1) % RING_DEPTH;
        end else begin
            slot = (ring_head + ring_fill) % RING_DEPTH;
            ring_fill++;
        end
        for (int k = 0; k < line_fill; k++) ring_chars[slot][k] = line_buf[k];
        ring_len[slot] = line_fill;
        line_fill = 0;
    endtask

    task automatic predict_status(input logic [1:0] op, input logic [7:0] b,
                                  input logic [7:0] idx, input logic [6:0] col);
        term_status_t st;
        int           pad;
        int           slot;
        st = '0;
        if (op == OP_PUT) begin
            if (b == CH_NEWLINE) begin
                commit_shadow_line();
                st.line_committed = 1'b1;
            end else begin
                if (b == CH_TAB) begin
                    // pad to the next tab stop, stop one short of a full line
                    pad = int'(TAB_STOP) - (line_fill % int'(TAB_STOP));
                    while (pad > 0 && line_fill < LINE_COLS - 1) begin
                        line_buf[line_fill] = CH_SPACE;
                        line_fill++;
                        pad--;
                    end
                end else if (b >= CH_FIRST_PRINT && b < CH_PAST_PRINT) begin
                    if (line_fill < LINE_COLS) begin
                        line_buf[line_fill] = b;
                        line_fill++;
                    end
                end
                if (line_fill >= LINE_COLS) begin
                    commit_shadow_line();
                    st.line_committed = 1'b1;
                end
            end
        end else if (op == OP_READ) begin
            if (int'(idx) < ring_fill) begin
                slot = (ring_head + int'(idx)) % RING_DEPTH;
                if (int'(col) < ring_len[slot] && int'(col) < LINE_COLS)
                    st.read_char = ring_chars[slot][col];
            end
        end else if (op == OP_CLEAR) begin
            ring_fill = 0;
            ring_head = 0;
        end
        st.line_count     = ring_fill[8:0];
        st.partial_length = line_fill[6:0];
        status_due_q.push_back(st);
    endtask

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: present the next pending transaction, predict it when accepted
    always @(posedge aclk) begin : drive_proc
        term_cmd_t nxt;
        bit        quiet;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_status(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[22:16]);
                items_taken++;
            end
            quiet = (items_taken >= 300 && items_taken < 450);
            if (!s_tvalid || s_tready) begin
                if (byte_cmd_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = byte_cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {1'b0, nxt.column, nxt.line_index, nxt.data_byte};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result, throttle m_tready, hold off once for a long stretch
    always @(posedge aclk) begin : watch_proc
        term_status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_due_q.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = status_due_q.pop_front();
                    check_field("read_char", 9'(want.read_char), 9'(m_tdata[7:0]));
                    check_field("line_count", want.line_count, m_tdata[16:8]);
                    check_field("partial_length", 9'(want.partial_length),
                                9'(m_tdata[23:17]));
                    check_field("line_committed", 9'(want.line_committed),
                                9'(m_tdata[24]));
                end
                results_seen++;
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (results_seen >= 500 && results_seen < 650) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic add_cmd(input logic [1:0] op, input logic [7:0] b,
                           input logic [7:0] idx, input logic [6:0] col);
        term_cmd_t c;
        c.op         = op;
        c.data_byte  = b;
        c.line_index = idx;
        c.column     = col;
        byte_cmd_q.push_back(c);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    initial begin : stim_proc
        int gen_lines;
        int pick;
        int n;
        int r;
        int top;
        gen_lines = 0;

        // directed: ignored bytes, printable extremes, tabs, empty line, reads, clear
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd0, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd255, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd31, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_PAST_PRINT, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_SPACE, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd65, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd126, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_TAB, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_TAB, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_NEWLINE, 8'd0, 7'd0);
        add_cmd(OP_PUT, CH_NEWLINE, 8'd0, 7'd0);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd0);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd7);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd2);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd8);
        add_cmd(OP_READ, 8'd0, 8'd1, 7'd0);
        add_cmd(OP_READ, 8'd0, 8'd255, 7'd89);
        add_cmd(OP_READ, 8'd0, 8'd2, 7'd89);
        add_cmd(OP_CLEAR, 8'd255, 8'd255, 7'd89);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd0);
        add_cmd(OP_PUT, 8'd122, 8'd255, 7'd89);
        add_cmd(OP_PUT, CH_NEWLINE, 8'd0, 7'd0);
        add_cmd(OP_READ, 8'd0, 8'd0, 7'd0);

        // random: mostly terminated lines and reads of held lines, some noise
        while (byte_cmd_q.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                n = $urandom_range(3, 20);
                repeat (n) add_cmd(OP_PUT, CH_NEWLINE, any_byte(), 7'($urandom_range(0, 89)));
                gen_lines += n;
            end else if (pick < 55) begin
                n = $urandom_range(0, 8);
                repeat (n) begin
                    r = $urandom_range(0, 9);
                    if (r == 7) add_cmd(OP_PUT, CH_TAB, any_byte(), 7'd0);
                    else if (r == 8) add_cmd(OP_PUT, any_byte(), any_byte(), 7'd0);
                    else add_cmd(OP_PUT, printable(), 8'd0, 7'd0);
                end
                // leave a line open now and then
                if ($urandom_range(0, 9) != 0) begin
                    add_cmd(OP_PUT, CH_NEWLINE, 8'd0, 7'd0);
                    gen_lines++;
                end
            end else if (pick < 57) begin
                // run past a full line so it commits on its own
                n = $urandom_range(86, 95);
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0) add_cmd(OP_PUT, CH_TAB, 8'd0, 7'd0);
                    else add_cmd(OP_PUT, printable(), 8'd0, 7'd0);
                end
                gen_lines++;
            end else if (pick < 59) begin
                // tabs close to the end of the line must not commit it
                n = $urandom_range(84, 88);
                repeat (n) add_cmd(OP_PUT, printable(), 8'd0, 7'd0);
                repeat ($urandom_range(1, 3)) add_cmd(OP_PUT, CH_TAB, 8'd0, 7'd0);
                add_cmd(OP_PUT, CH_NEWLINE, 8'd0, 7'd0);
                gen_lines++;
            end else if (pick < 89) begin
                top = (gen_lines > RING_DEPTH) ? RING_DEPTH : gen_lines;
                repeat ($urandom_range(1, 4)) begin
                    if (top > 0 && $urandom_range(0, 99) < 85)
                        r = $urandom_range(0, top - 1);
                    else
                        r = $urandom_range(0, 255);
                    if ($urandom_range(0, 9) < 7)
                        add_cmd(OP_READ, any_byte(), 8'(r), 7'($urandom_range(0, 12)));
                    else
                        add_cmd(OP_READ, any_byte(), 8'(r), 7'($urandom_range(0, 89)));
                end
            end else if (pick < 97) begin
                add_cmd(OP_PUT, any_byte(), any_byte(), 7'($urandom_range(0, 89)));
            end else if (gen_lines >= 300) begin
                // clear only once the ring has wrapped
                add_cmd(OP_CLEAR, any_byte(), any_byte(), 7'($urandom_range(0, 89)));
                gen_lines = 0;
            end else begin
                add_cmd(OP_READ, any_byte(), any_byte(), 7'($urandom_range(0, 89)));
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_cmd_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (status_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : limit_proc
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ text_line_assembler_scrollback.f @@
hdl/tlas_pkg.sv
hdl/tlas_slot_unit.sv
hdl/tlas_line_buf.sv
hdl/tlas_history.sv
hdl/text_line_assembler_scrollback.sv
tb/sv/tb_top.sv
